// ===== rtl/core/fsfp_pkg.sv =====
// Shared types, codes and constants for the flow sensor frame parser.
package fsfp_pkg;

  localparam int unsigned CAPTURE_BYTES = 16;
  localparam int unsigned CAP_IDX_W     = $clog2(CAPTURE_BYTES);

  localparam logic [7:0] HDR_FIRST    = 8'hAA;
  localparam logic [7:0] HDR_SECOND   = 8'hFF;
  localparam logic [7:0] FC_FLOW      = 8'h51;
  localparam logic [7:0] FC_RANGE     = 8'h34;
  localparam logic [7:0] FC_INERTIAL  = 8'h01;
  localparam logic [7:0] FC_ATTITUDE  = 8'h04;
  localparam logic [7:0] MODE_RAW     = 8'h00;
  localparam logic [7:0] MODE_FUSED   = 8'h01;
  localparam logic [7:0] MODE_INS     = 8'h02;
  localparam logic [7:0] QUAL_THR_RST = 8'd55;
  localparam logic [31:0] DIST_NONE   = 32'hFFFF_FFFF;

  typedef logic [CAPTURE_BYTES-1:0][7:0] cap_t;

  typedef enum logic [2:0] {
    PH_HUNT_AA = 3'd0,
    PH_HUNT_FF = 3'd1,
    PH_FUNC    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SUM     = 3'd5,
    PH_ADD     = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_FLOW     = 2'd0,
    KIND_RANGE    = 2'd1,
    KIND_INERTIAL = 2'd2,
    KIND_ATTITUDE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CK_FAIL  = 2'd1,
    ST_LOW_QUAL = 2'd2,
    ST_DIST_BAD = 2'd3
  } status_e;

  // parser -> result stage
  typedef struct packed {
    logic       last_byte;  // next accepted byte closes a frame
    logic       done;       // add byte accepted this cycle
    logic       ck_ok;      // sum and add both matched
    logic [7:0] func;
  } frame_t;

  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic [7:0]         mode;
    logic signed [15:0] val_a;
    logic signed [15:0] val_b;
    logic signed [15:0] val_c;
    logic signed [15:0] val_d;
    logic signed [15:0] val_e;
    logic signed [15:0] val_f;
    logic signed [31:0] range_dist;
    logic [7:0]         qual;
  } result_t;

endpackage

// ===== rtl/core/fsfp_parser.sv =====
// Byte framing state machine, checksum accumulators and payload capture.
module fsfp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  output fsfp_pkg::frame_t    frame_o,
  output fsfp_pkg::cap_t      cap_o
);

  fsfp_pkg::phase_e phase_q, phase_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [7:0] func_q, func_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] add_q, add_d;
  logic       match_q, match_d;
  logic [7:0] sum_acc;
  logic [7:0] add_acc;
  logic [7:0] pos_inc;
  fsfp_pkg::cap_t cap_q;

  assign sum_acc = sum_q + rx_byte_i;
  assign add_acc = add_q + sum_acc;
  assign pos_inc = pos_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fsfp_pkg::PH_HUNT_AA;
      pos_q   <= '0;
      len_q   <= '0;
      func_q  <= '0;
      sum_q   <= '0;
      add_q   <= '0;
      match_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      func_q  <= func_d;
      sum_q   <= sum_d;
      add_q   <= add_d;
      match_q <= match_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    len_d   = len_q;
    func_d  = func_q;
    sum_d   = sum_q;
    add_d   = add_q;
    match_d = match_q;
    case (phase_q)
      fsfp_pkg::PH_HUNT_FF: begin
        if (rx_byte_i == fsfp_pkg::HDR_SECOND) begin
          sum_d   = sum_acc;
          add_d   = add_acc;
          phase_d = fsfp_pkg::PH_FUNC;
        end else if (rx_byte_i == fsfp_pkg::HDR_FIRST) begin
          // restart the header on a repeated first byte
          sum_d = fsfp_pkg::HDR_FIRST;
          add_d = fsfp_pkg::HDR_FIRST;
        end else begin
          phase_d = fsfp_pkg::PH_HUNT_AA;
        end
      end
      fsfp_pkg::PH_FUNC: begin
        func_d  = rx_byte_i;
        sum_d   = sum_acc;
        add_d   = add_acc;
        phase_d = fsfp_pkg::PH_LEN;
      end
      fsfp_pkg::PH_LEN: begin
        len_d   = rx_byte_i;
        pos_d   = '0;
        sum_d   = sum_acc;
        add_d   = add_acc;
        phase_d = (rx_byte_i == 8'd0) ? fsfp_pkg::PH_SUM : fsfp_pkg::PH_PAYLOAD;
      end
      fsfp_pkg::PH_PAYLOAD: begin
        sum_d = sum_acc;
        add_d = add_acc;
        pos_d = pos_inc;
        if (pos_inc == len_q) begin
          phase_d = fsfp_pkg::PH_SUM;
        end
      end
      fsfp_pkg::PH_SUM: begin
        match_d = (rx_byte_i == sum_q);
        phase_d = fsfp_pkg::PH_ADD;
      end
      fsfp_pkg::PH_ADD: begin
        phase_d = fsfp_pkg::PH_HUNT_AA;
      end
      default: begin
        if (rx_byte_i == fsfp_pkg::HDR_FIRST) begin
          sum_d   = fsfp_pkg::HDR_FIRST;
          add_d   = fsfp_pkg::HDR_FIRST;
          phase_d = fsfp_pkg::PH_HUNT_FF;
        end else begin
          phase_d = fsfp_pkg::PH_HUNT_AA;
        end
      end
    endcase
  end

  // bytes past the capture depth only feed the checksum
  always_ff @(posedge clk_i) begin
    if (accept_i && phase_q == fsfp_pkg::PH_PAYLOAD &&
        pos_q < 8'(fsfp_pkg::CAPTURE_BYTES)) begin
      cap_q[pos_q[fsfp_pkg::CAP_IDX_W-1:0]] <= rx_byte_i;
    end
  end

  assign frame_o.last_byte = (phase_q == fsfp_pkg::PH_ADD);
  assign frame_o.done      = accept_i && (phase_q == fsfp_pkg::PH_ADD);
  assign frame_o.ck_ok     = match_q && (rx_byte_i == add_q);
  assign frame_o.func      = func_q;
  assign cap_o             = cap_q;

endmodule

// ===== rtl/core/fsfp_result.sv =====
// Frame decode, mode 2 quality store and the result register.
module fsfp_result (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fsfp_pkg::frame_t    frame_i,
  input  fsfp_pkg::cap_t      cap_i,
  input  logic [7:0]          qual_thr_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output fsfp_pkg::result_t   result_o
);

  fsfp_pkg::result_t res_d, res_q;
  logic       known;
  logic       valid_q, valid_d;
  logic [7:0] squal_q, squal_d;
  logic [7:0] mode;
  logic [7:0] qual;
  logic [31:0] dist_word;

  assign mode = cap_i[0];
  assign dist_word = {cap_i[6], cap_i[5], cap_i[4], cap_i[3]};
  // a mode 2 frame refreshes the stored quality before the test
  assign qual = (mode == fsfp_pkg::MODE_INS) ? cap_i[14] : squal_q;

  always_comb begin
    res_d   = '0;
    known   = 1'b1;
    squal_d = squal_q;
    case (frame_i.func)
      fsfp_pkg::FC_FLOW: begin
        res_d.kind = fsfp_pkg::KIND_FLOW;
        res_d.mode = mode;
        res_d.qual = qual;
        if (mode == fsfp_pkg::MODE_INS) begin
          res_d.val_a = {cap_i[3], cap_i[2]};
          res_d.val_b = {cap_i[5], cap_i[4]};
          res_d.val_c = {cap_i[7], cap_i[6]};
          res_d.val_d = {cap_i[9], cap_i[8]};
          res_d.val_e = {cap_i[11], cap_i[10]};
          res_d.val_f = {cap_i[13], cap_i[12]};
          squal_d     = cap_i[14];
        end else if (mode == fsfp_pkg::MODE_FUSED) begin
          res_d.val_a = {cap_i[3], cap_i[2]};
          res_d.val_b = {cap_i[5], cap_i[4]};
        end else if (mode == fsfp_pkg::MODE_RAW) begin
          res_d.val_a = {8'd0, cap_i[2]};
          res_d.val_b = {8'd0, cap_i[3]};
        end
        if (qual < qual_thr_i) begin
          res_d.status = fsfp_pkg::ST_LOW_QUAL;
        end else begin
          res_d.status = frame_i.ck_ok ? fsfp_pkg::ST_OK : fsfp_pkg::ST_CK_FAIL;
        end
      end
      fsfp_pkg::FC_RANGE: begin
        res_d.kind       = fsfp_pkg::KIND_RANGE;
        res_d.range_dist = dist_word;
        if (!frame_i.ck_ok) begin
          res_d.status = fsfp_pkg::ST_CK_FAIL;
        end else if (dist_word == fsfp_pkg::DIST_NONE) begin
          res_d.status = fsfp_pkg::ST_DIST_BAD;
        end else begin
          res_d.status = fsfp_pkg::ST_OK;
        end
      end
      fsfp_pkg::FC_INERTIAL: begin
        res_d.kind   = fsfp_pkg::KIND_INERTIAL;
        res_d.status = frame_i.ck_ok ? fsfp_pkg::ST_OK : fsfp_pkg::ST_CK_FAIL;
        res_d.val_a  = {cap_i[1], cap_i[0]};
        res_d.val_b  = {cap_i[3], cap_i[2]};
        res_d.val_c  = {cap_i[5], cap_i[4]};
        res_d.val_d  = {cap_i[7], cap_i[6]};
        res_d.val_e  = {cap_i[9], cap_i[8]};
        res_d.val_f  = {cap_i[11], cap_i[10]};
      end
      fsfp_pkg::FC_ATTITUDE: begin
        res_d.kind   = fsfp_pkg::KIND_ATTITUDE;
        res_d.status = frame_i.ck_ok ? fsfp_pkg::ST_OK : fsfp_pkg::ST_CK_FAIL;
        res_d.val_a  = {cap_i[1], cap_i[0]};
        res_d.val_b  = {cap_i[3], cap_i[2]};
        res_d.val_c  = {cap_i[5], cap_i[4]};
        res_d.val_d  = {cap_i[7], cap_i[6]};
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // top level holds off a closing byte while a stalled result is pending
  always_comb begin
    valid_d = valid_q;
    if (frame_i.done && known) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      squal_q <= '0;
    end else begin
      valid_q <= valid_d;
      if (frame_i.done) begin
        squal_q <= squal_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.done && known) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

// ===== rtl/core/flow_sensor_frame_parser_core.sv =====
// Top level of the flow sensor frame parser: handshakes and threshold register.
// Takes one byte per cycle unless stalled as below; a frame's result is registered in the cycle after its add byte.
// Throughput: one byte every cycle; the one result register only holds off the
// closing byte of a frame while an earlier result is still stalled.
// Reset clears the framing state, the stored quality and the result valid and
// sets the quality threshold to 55; the payload capture is not cleared.
module flow_sensor_frame_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         frame_kind_o,
  output logic [1:0]         frame_status_o,
  output logic [7:0]         flow_mode_o,
  output logic signed [15:0] value_a_o,
  output logic signed [15:0] value_b_o,
  output logic signed [15:0] value_c_o,
  output logic signed [15:0] value_d_o,
  output logic signed [15:0] value_e_o,
  output logic signed [15:0] value_f_o,
  output logic signed [31:0] distance_o,
  output logic [7:0]         quality_o
);

  fsfp_pkg::frame_t  frame;
  fsfp_pkg::cap_t    cap;
  fsfp_pkg::result_t result;
  logic              accept;
  logic [7:0]        qual_thr_q;

  assign in_stall_o  = frame.last_byte && out_valid_o && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qual_thr_q <= fsfp_pkg::QUAL_THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      qual_thr_q <= cfg_data_i;
    end
  end

  fsfp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .frame_o   (frame),
    .cap_o     (cap)
  );

  fsfp_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (frame),
    .cap_i       (cap),
    .qual_thr_i  (qual_thr_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign frame_kind_o   = result.kind;
  assign frame_status_o = result.status;
  assign flow_mode_o    = result.mode;
  assign value_a_o      = result.val_a;
  assign value_b_o      = result.val_b;
  assign value_c_o      = result.val_c;
  assign value_d_o      = result.val_d;
  assign value_e_o      = result.val_e;
  assign value_f_o      = result.val_f;
  assign distance_o     = result.range_dist;
  assign quality_o      = result.qual;

endmodule
